[design/hnd_pkg.sv]
// Shared types, constants and the CRC helper for the HDLC NRZI deframer.
// Used by hnd_deframer and hdlc_nrzi_deframer_crc_check; depends on nothing.
package hnd_pkg;

  localparam int MAX_FRAME_BYTES = 512;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES);
  localparam int LEN_W           = 9;

  localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(MAX_FRAME_BYTES - 1);
  localparam logic [15:0]      CRC_INIT      = 16'hFFFF;
  localparam logic [15:0]      CRC_GOOD      = 16'hF0B8;
  localparam logic [15:0]      CRC_POLY      = 16'h8408;
  localparam logic [3:0]       RUN_SAT       = 4'd8;
  localparam logic [3:0]       RUN_FLAG      = 4'd6;
  localparam logic [3:0]       RUN_STUFF     = 4'd5;
  localparam logic [2:0]       POS_LAST      = 3'd7;
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 9'd18;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_SEEN,
    PH_IN_FRAME
  } phase_t;

  typedef enum logic [1:0] {
    EV_DATA,
    EV_GOOD,
    EV_BAD,
    EV_ABORT
  } ev_kind_t;

  typedef struct packed {
    logic             valid;
    ev_kind_t         kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Low LEN_W bits of a byte count, zero-extended when the count is narrower.
  function automatic logic [LEN_W-1:0] cnt_to_len(logic [CNT_W-1:0] c);
    logic [CNT_W+LEN_W-1:0] ext;
    ext = {{LEN_W{1'b0}}, c};
    return ext[LEN_W-1:0];
  endfunction

endpackage

[design/hnd_deframer.sv]
// Per-bit deframing datapath: NRZI decode, flag/abort/stuff detection,
// byte assembly, byte count and CRC-16 state. Depends on hnd_pkg.
module hnd_deframer
  import hnd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic             line_bit,
  input  logic [LEN_W-1:0] min_length,
  output result_t          res
);

  phase_t         phase_r, phase_nxt;
  logic           prev_r, prev_nxt;
  logic [3:0]     run_r, run_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic [2:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]    crc_r, crc_nxt;

  logic           dbit;
  logic           is_abort;
  logic           is_flag;
  logic           is_stuff;
  logic           byte_done;
  logic           in_frame_byte;
  logic           overflow;
  logic           store;
  logic           active;
  logic           len_ok;
  logic [7:0]     byte_sh;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0]    crc_new;

  // Decode of the current bit against the state.
  always_comb begin
    dbit          = (line_bit == prev_r);
    is_abort      = !dbit && (run_r > RUN_FLAG);
    is_flag       = !dbit && (run_r == RUN_FLAG);
    is_stuff      = !dbit && (run_r == RUN_STUFF);
    byte_sh       = {dbit, byte_r[7:1]};
    byte_done     = !(is_abort || is_flag || is_stuff) && (pos_r == POS_LAST);
    active        = phase_r inside {PH_SEEN, PH_IN_FRAME};
    in_frame_byte = byte_done && active;
    overflow      = in_frame_byte && (cnt_r >= CNT_LAST);
    store         = in_frame_byte && !overflow;
    cnt_inc       = cnt_r + 1'b1;
    crc_new       = crc_fold(crc_r, byte_sh);
    len_ok        = {{LEN_W{1'b0}}, cnt_r} >= {{CNT_W{1'b0}}, min_length};
  end

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    run_nxt   = run_r;
    byte_nxt  = byte_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    if (step_en) begin
      prev_nxt = line_bit;
      if (is_abort || is_flag || overflow) begin
        phase_nxt = is_flag ? PH_SEEN : PH_WAIT;
        run_nxt   = '0;
        byte_nxt  = '0;
        pos_nxt   = '0;
        cnt_nxt   = '0;
        crc_nxt   = CRC_INIT;
      end else if (is_stuff) begin
        run_nxt = '0;
      end else begin
        if (dbit) begin
          run_nxt = (run_r < RUN_SAT) ? run_r + 1'b1 : run_r;
        end else begin
          run_nxt = '0;
        end
        byte_nxt = byte_sh;
        pos_nxt  = pos_r + 1'b1;
        if (store) begin
          phase_nxt = PH_IN_FRAME;
          cnt_nxt   = cnt_inc;
          crc_nxt   = crc_new;
        end
      end
    end
  end

  // Result of the current bit.
  always_comb begin
    res = '{valid: 1'b0, kind: EV_DATA, data: 8'h00, len: cnt_to_len(cnt_r)};
    if (is_abort) begin
      res.valid = active;
      res.kind  = EV_ABORT;
    end else if (is_flag) begin
      res.valid = (phase_r == PH_IN_FRAME);
      res.kind  = (len_ok && (crc_r == CRC_GOOD)) ? EV_GOOD : EV_BAD;
    end else if (overflow) begin
      res.valid = 1'b1;
      res.kind  = EV_ABORT;
    end else if (store) begin
      res.valid = 1'b1;
      res.kind  = EV_DATA;
      res.data  = byte_sh;
      res.len   = cnt_to_len(cnt_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      prev_r  <= 1'b0;
      run_r   <= '0;
      byte_r  <= '0;
      pos_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= CRC_INIT;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      run_r   <= run_nxt;
      byte_r  <= byte_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_run_sat: assert property (@(posedge clk) disable iff (!rst_n) run_r <= RUN_SAT)
    else $error("ones run counter beyond saturation");

  a_data_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.valid && (res.kind == EV_DATA) |=> phase_r == PH_IN_FRAME)
    else $error("data byte emitted without entering a frame");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.valid && (res.kind != EV_DATA) |=> (cnt_r == '0) && (crc_r == CRC_INIT))
    else $error("frame end did not clear count and CRC");
`endif

endmodule

[design/hdlc_nrzi_deframer_crc_check.sv]
// Top level of the HDLC NRZI deframer with CRC-16 check: input register,
// configuration register, result register. Depends on hnd_pkg and hnd_deframer.
// A line bit accepted into the input register is processed by the deframer, and its result is registered at out_*.
// Throughput: one line bit per cycle, except while a result waits in the result register with out_ready low.
// The input register lets one new bit be taken while a finished result waits.
// Reset (rst_n low, synchronous): waiting for flag, CRC 0xFFFF, min_length 18.
module hdlc_nrzi_deframer_crc_check
  import hnd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_line_bit,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_event_kind,
  output logic [7:0]       out_data_byte,
  output logic [LEN_W-1:0] out_frame_length,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_min_length
);

  // Input stage: holds one accepted line bit until the deframer consumes it.
  logic             in_valid_r;
  logic             in_bit_r;
  // Configuration register.
  logic [LEN_W-1:0] min_length_r;
  // Result stage.
  logic             out_valid_r;
  ev_kind_t         out_kind_r;
  logic [7:0]       out_data_r;
  logic [LEN_W-1:0] out_len_r;

  logic    fire;
  result_t res;

  // A held bit is processed whenever the result register can take whatever it
  // produces: either it is empty or its contents leave in this same transfer.
  assign fire      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  hnd_deframer u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (fire),
    .line_bit   (in_bit_r),
    .min_length (min_length_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_bit_r <= in_line_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MIN_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_length_r <= cfg_min_length;
    end
  end

  // The result register loads on a bit that produces a result, and otherwise
  // empties once its contents have been transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_kind_r <= res.kind;
      out_data_r <= res.data;
      out_len_r  <= res.len;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_data_byte    = out_data_r;
  assign out_frame_length = out_len_r;

`ifndef SYNTHESIS
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.valid |=> out_valid_r)
    else $error("result produced but not presented");

  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full result stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !(fire && res.valid) |=> !out_valid_r)
    else $error("result repeated after transfer");
`endif

endmodule
